### design/isodt_pkg.sv
// Shared types and constants for the ISO 8601 date/time parser.
// Holds the parse phase, error codes, parser state and result records.
// No dependencies.
`default_nettype none

package isodt_pkg;

   // Parse phase, one-hot. The date phases occupy bits 0 through 9.
   typedef enum logic [26:0] {
      PH_D0         = 27'd1 << 0,
      PH_D1         = 27'd1 << 1,
      PH_SEL        = 27'd1 << 2,
      PH_Y3         = 27'd1 << 3,
      PH_DASH1      = 27'd1 << 4,
      PH_MO0        = 27'd1 << 5,
      PH_MO1        = 27'd1 << 6,
      PH_DASH2      = 27'd1 << 7,
      PH_DA0        = 27'd1 << 8,
      PH_DA1        = 27'd1 << 9,
      PH_AFTER_DATE = 27'd1 << 10,
      PH_H0         = 27'd1 << 11,
      PH_H1         = 27'd1 << 12,
      PH_COL1       = 27'd1 << 13,
      PH_MI0        = 27'd1 << 14,
      PH_MI1        = 27'd1 << 15,
      PH_COL2       = 27'd1 << 16,
      PH_S0         = 27'd1 << 17,
      PH_S1         = 27'd1 << 18,
      PH_AFTER_TIME = 27'd1 << 19,
      PH_ZH0        = 27'd1 << 20,
      PH_ZH1        = 27'd1 << 21,
      PH_ZCOL       = 27'd1 << 22,
      PH_ZM0        = 27'd1 << 23,
      PH_ZM1        = 27'd1 << 24,
      PH_END        = 27'd1 << 25,
      PH_ERR        = 27'd1 << 26
   } phase_type;

   localparam int DATE_PHASE_MSB = 9;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_SYNTAX = 3'd1,
      ERR_MONTH  = 3'd2,
      ERR_DAY    = 3'd3,
      ERR_HOUR   = 3'd4,
      ERR_MINUTE = 3'd5,
      ERR_SECOND = 3'd6
   } err_type;

   typedef enum logic [1:0] {
      ZONE_NONE  = 2'd0,
      ZONE_UTC   = 2'd1,
      ZONE_PLUS  = 2'd2,
      ZONE_MINUS = 2'd3
   } zone_type;

   typedef struct packed {
      phase_type   phase;
      logic [13:0] accum;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      zone_type    zone_kind;
      logic [6:0]  zone_hours;
      logic [12:0] zone_offset;
      err_type     error;
      logic        lead_bad;
      logic        zone_neg;
   } state_type;

   localparam state_type ST_RESET = '{
      phase:       PH_D0,
      accum:       14'd0,
      year:        14'd0,
      month:       4'd0,
      day:         5'd0,
      hour:        5'd0,
      minute:      6'd0,
      second:      6'd0,
      zone_kind:   ZONE_NONE,
      zone_hours:  7'd0,
      zone_offset: 13'd0,
      error:       ERR_NONE,
      lead_bad:    1'b0,
      zone_neg:    1'b0
   };

   typedef struct packed {
      logic [12:0] zone_offset_min;
      zone_type    zone_kind;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      err_type     error_code;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);
   localparam int RSP_BYTES   = (RESULT_BITS + 7) / 8;

endpackage

`default_nettype wire

### design/isodt_step.sv
// Per-character transition of the parser: next state and the result record.
// Purely combinational; depends on isodt_pkg.
`default_nettype none

module isodt_step (
   input  isodt_pkg::state_type  st,
   input  logic [7:0]            char_in,
   input  logic                  last_char,
   output isodt_pkg::state_type  st_next,
   output isodt_pkg::result_type res
);

   logic                 d_ok;
   logic [3:0]           d;
   logic [17:0]          acc10;
   logic [6:0]           v;
   logic [12:0]          zh60;
   logic [12:0]          zoff;
   isodt_pkg::err_type   fail_code;
   isodt_pkg::state_type nx;
   isodt_pkg::state_type zs;
   isodt_pkg::state_type fin;

   always_comb begin
      d_ok      = (char_in >= 8'h30) && (char_in <= 8'h39);
      d         = char_in[3:0];
      acc10     = {4'b0, st.accum} * 18'd10 + {14'b0, d};
      v         = acc10[6:0];
      zh60      = {st.zone_hours, 6'b0} - {4'b0, st.zone_hours, 2'b0};
      zoff      = zh60 + {6'b0, v};
      fail_code = st.lead_bad ? isodt_pkg::ERR_HOUR : isodt_pkg::ERR_SYNTAX;

      // zone designator or sign after a complete date or time
      zs = st;
      if (char_in == "Z") begin
         zs.zone_kind = isodt_pkg::ZONE_UTC;
         zs.phase     = isodt_pkg::PH_END;
      end else if (char_in == "+" || char_in == "-") begin
         zs.zone_neg = (char_in == "-");
         zs.phase    = isodt_pkg::PH_ZH0;
      end else begin
         zs.error = isodt_pkg::ERR_SYNTAX;
         zs.phase = isodt_pkg::PH_ERR;
      end

      nx = st;
      unique case (st.phase)
         isodt_pkg::PH_D0, isodt_pkg::PH_MO0, isodt_pkg::PH_DA0: begin
            if (!d_ok) begin
               nx.error = fail_code;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               nx.accum = {10'b0, d};
               nx.phase = (st.phase == isodt_pkg::PH_D0)  ? isodt_pkg::PH_D1 :
                          (st.phase == isodt_pkg::PH_MO0) ? isodt_pkg::PH_MO1 :
                                                            isodt_pkg::PH_DA1;
            end
         end
         isodt_pkg::PH_D1: begin
            if (!d_ok) begin
               nx.error = fail_code;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               nx.accum    = acc10[13:0];
               nx.lead_bad = (acc10[13:0] >= 14'd24);
               nx.phase    = isodt_pkg::PH_SEL;
            end
         end
         isodt_pkg::PH_SEL: begin
            if (d_ok) begin
               nx.accum = acc10[13:0];
               nx.phase = isodt_pkg::PH_Y3;
            end else if (st.lead_bad) begin
               nx.error = isodt_pkg::ERR_HOUR;
               nx.phase = isodt_pkg::PH_ERR;
            end else if (char_in == ":") begin
               nx.hour  = st.accum[4:0];
               nx.phase = isodt_pkg::PH_MI0;
            end else begin
               nx.error = isodt_pkg::ERR_SYNTAX;
               nx.phase = isodt_pkg::PH_ERR;
            end
         end
         isodt_pkg::PH_Y3: begin
            if (!d_ok) begin
               nx.error = fail_code;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               nx.accum = acc10[13:0];
               nx.year  = acc10[13:0];
               nx.phase = isodt_pkg::PH_DASH1;
            end
         end
         isodt_pkg::PH_DASH1, isodt_pkg::PH_DASH2: begin
            if (char_in != "-") begin
               nx.error = fail_code;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               nx.phase = (st.phase == isodt_pkg::PH_DASH1) ? isodt_pkg::PH_MO0
                                                            : isodt_pkg::PH_DA0;
            end
         end
         isodt_pkg::PH_MO1: begin
            if (!d_ok) begin
               nx.error = fail_code;
               nx.phase = isodt_pkg::PH_ERR;
            end else if (v == 7'd0 || v > 7'd12) begin
               nx.error = isodt_pkg::ERR_MONTH;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               nx.month = v[3:0];
               nx.phase = isodt_pkg::PH_DASH2;
            end
         end
         isodt_pkg::PH_DA1: begin
            if (!d_ok) begin
               nx.error = fail_code;
               nx.phase = isodt_pkg::PH_ERR;
            end else if (v == 7'd0 || v > 7'd31) begin
               nx.error = isodt_pkg::ERR_DAY;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               nx.day   = v[4:0];
               nx.phase = isodt_pkg::PH_AFTER_DATE;
            end
         end
         isodt_pkg::PH_AFTER_DATE: begin
            if (char_in == "T") begin
               nx.phase = isodt_pkg::PH_H0;
            end else begin
               nx = zs;
            end
         end
         isodt_pkg::PH_AFTER_TIME: begin
            nx = zs;
         end
         isodt_pkg::PH_H0, isodt_pkg::PH_MI0, isodt_pkg::PH_S0,
         isodt_pkg::PH_ZH0, isodt_pkg::PH_ZM0: begin
            if (!d_ok) begin
               nx.error = isodt_pkg::ERR_SYNTAX;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               nx.accum = {10'b0, d};
               nx.phase = isodt_pkg::phase_type'({st.phase[25:0], 1'b0});
            end
         end
         isodt_pkg::PH_H1, isodt_pkg::PH_MI1, isodt_pkg::PH_S1, isodt_pkg::PH_ZH1: begin
            if (!d_ok) begin
               nx.error = isodt_pkg::ERR_SYNTAX;
               nx.phase = isodt_pkg::PH_ERR;
            end else if (st.phase == isodt_pkg::PH_H1 && v > 7'd23) begin
               nx.error = isodt_pkg::ERR_HOUR;
               nx.phase = isodt_pkg::PH_ERR;
            end else if (st.phase == isodt_pkg::PH_MI1 && v > 7'd59) begin
               nx.error = isodt_pkg::ERR_MINUTE;
               nx.phase = isodt_pkg::PH_ERR;
            end else if (st.phase == isodt_pkg::PH_S1 && v > 7'd59) begin
               nx.error = isodt_pkg::ERR_SECOND;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               if (st.phase == isodt_pkg::PH_H1) nx.hour = v[4:0];
               if (st.phase == isodt_pkg::PH_MI1) nx.minute = v[5:0];
               if (st.phase == isodt_pkg::PH_S1) nx.second = v[5:0];
               if (st.phase == isodt_pkg::PH_ZH1) nx.zone_hours = v;
               nx.phase = isodt_pkg::phase_type'({st.phase[25:0], 1'b0});
            end
         end
         isodt_pkg::PH_COL1, isodt_pkg::PH_COL2, isodt_pkg::PH_ZCOL: begin
            if (char_in != ":") begin
               nx.error = isodt_pkg::ERR_SYNTAX;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               nx.phase = isodt_pkg::phase_type'({st.phase[25:0], 1'b0});
            end
         end
         isodt_pkg::PH_ZM1: begin
            if (!d_ok) begin
               nx.error = isodt_pkg::ERR_SYNTAX;
               nx.phase = isodt_pkg::PH_ERR;
            end else begin
               nx.zone_offset = zoff;
               nx.zone_kind   = st.zone_neg ? isodt_pkg::ZONE_MINUS : isodt_pkg::ZONE_PLUS;
               nx.phase       = isodt_pkg::PH_END;
            end
         end
         isodt_pkg::PH_ERR: begin
            // hold until the last beat of the string
            nx = st;
         end
         isodt_pkg::PH_END: begin
            nx.error = isodt_pkg::ERR_SYNTAX;
            nx.phase = isodt_pkg::PH_ERR;
         end
         default: begin
            nx.error = isodt_pkg::ERR_SYNTAX;
            nx.phase = isodt_pkg::PH_ERR;
         end
      endcase

      // end of string: an unfinished form is an error
      fin = nx;
      if (fin.error == isodt_pkg::ERR_NONE && fin.phase != isodt_pkg::PH_AFTER_DATE &&
          fin.phase != isodt_pkg::PH_AFTER_TIME && fin.phase != isodt_pkg::PH_END) begin
         if (|fin.phase[isodt_pkg::DATE_PHASE_MSB:0]) begin
            fin.error = fin.lead_bad ? isodt_pkg::ERR_HOUR : isodt_pkg::ERR_SYNTAX;
         end else begin
            fin.error = isodt_pkg::ERR_SYNTAX;
         end
      end

      res = '0;
      res.error_code = fin.error;
      if (fin.error == isodt_pkg::ERR_NONE) begin
         res.year            = fin.year;
         res.month           = fin.month;
         res.day             = fin.day;
         res.hour            = fin.hour;
         res.minute          = fin.minute;
         res.second          = fin.second;
         res.zone_kind       = fin.zone_kind;
         res.zone_offset_min = fin.zone_offset;
      end

      st_next = last_char ? isodt_pkg::ST_RESET : nx;
   end

endmodule

`default_nettype wire

### design/iso8601_datetime_parser.sv
// Top level of the ISO 8601 date/time parser: input register, parser state,
// result register. Depends on isodt_pkg and isodt_step.
`default_nettype none

// Usage
//   req channel: one character per beat on req_tdata, req_tlast set on the
//   final character of a string. Every string yields exactly one beat on the
//   rsp channel, carrying the parsed fields or an error code.
//   Forms: YYYY-MM-DDThh:mm:ss, YYYY-MM-DD or hh:mm:ss, each with an
//   optional zone (Z, +hh:mm, -hh:mm).
// Timing
//   One character per cycle sustained while no last character waits on a
//   pending result. Each character is held in the input register while the
//   state update is computed from it; the result of the last character is
//   written to the result register, which drives rsp_tvalid.
//   The throughput is set by the single per-character state update.
// Reset
//   Synchronous reset empties both registers and returns the parser to the
//   start of a string.
// Backpressure
//   While rsp is stalled, characters before the last one keep flowing; the
//   last character of the next string waits in the input register until the
//   pending result has been taken.

module iso8601_datetime_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire logic        req_tlast,   // last_char
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [isodt_pkg::RSP_BYTES*8-1:0] rsp_tdata
   // rsp_tdata from bit 0: error_code[2:0], year[16:3], month[20:17], day[25:21],
   // hour[30:26], minute[36:31], second[42:37], zone_kind[44:43],
   // zone_offset_min[57:45], zero fill above
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff;
   logic                  in_last_ff;
   isodt_pkg::state_type  state_ff, state_in;
   logic                  out_valid_ff, out_valid_in;
   isodt_pkg::result_type out_ff;
   isodt_pkg::state_type  step_next;
   isodt_pkg::result_type step_res;
   logic                  step_go;
   logic                  req_fire;

   isodt_step u_step (
      .st        (state_ff),
      .char_in   (in_char_ff),
      .last_char (in_last_ff),
      .st_next   (step_next),
      .res       (step_res)
   );

   // a last beat may only advance when the result slot is free or draining
   assign step_go    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_go;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end
      state_in = step_go ? step_next : state_ff;
      out_valid_in = out_valid_ff;
      if (step_go && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= isodt_pkg::ST_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step_go && in_last_ff) begin
         out_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(isodt_pkg::RSP_BYTES*8 - isodt_pkg::RESULT_BITS){1'b0}}, out_ff};

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.phase))
      else $error("parse phase not one-hot");

   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == isodt_pkg::PH_ERR) == (state_ff.error != isodt_pkg::ERR_NONE))
      else $error("error code and error phase disagree");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      step_go && in_last_ff |=> state_ff.phase == isodt_pkg::PH_D0)
      else $error("parser did not restart after a string");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !(step_go && in_last_ff))
      else $error("pending result overwritten");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.error_code != isodt_pkg::ERR_NONE
         |-> out_ff[isodt_pkg::RESULT_BITS-1:3] == '0)
      else $error("error result carries field data");

endmodule

`default_nettype wire

### tb/sv/iso8601_datetime_parser_tb.sv
// Testbench for iso8601_datetime_parser: directed and random strings fed as character beats,
// results checked against a cycle-free predictor. Depends on isodt_pkg and the parser RTL.
module iso8601_datetime_parser_tb;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   typedef byte unsigned char_list_type[$];

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata  = '0;   // [7:0] char_in
   logic                              req_tlast  = 1'b0; // last_char
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [isodt_pkg::RSP_BYTES*8-1:0] rsp_tdata;  // error_code, year, month, day, hour,
                                                  // minute, second, zone_kind, zone_offset_min

   char_beat_type         char_q[$];
   isodt_pkg::result_type parsed_q[$];
   isodt_pkg::state_type  prs = isodt_pkg::ST_RESET;
   int                    send_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    mismatches    = 0;
   int                    results_seen  = 0;

   iso8601_datetime_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- expected-result predictor ----------------

   function automatic void flag(isodt_pkg::err_type code);
      prs.error = code;
      prs.phase = isodt_pkg::PH_ERR;
   endfunction

   // incomplete date: the string is read as a time, leading pair as the hour
   function automatic void date_broken();
      if (prs.lead_bad) flag(isodt_pkg::ERR_HOUR);
      else flag(isodt_pkg::ERR_SYNTAX);
   endfunction

   function automatic void zone_open(logic [7:0] c);
      if (c == "Z") begin
         prs.zone_kind = isodt_pkg::ZONE_UTC;
         prs.phase     = isodt_pkg::PH_END;
      end else if (c == "+" || c == "-") begin
         prs.zone_neg = (c == "-");
         prs.phase    = isodt_pkg::PH_ZH0;
      end else begin
         flag(isodt_pkg::ERR_SYNTAX);
      end
   endfunction

   // second digit of a two-digit field; on success the value is left in accum
   function automatic bit pair_ok(int d, int lo, int hi, isodt_pkg::err_type code);
      int v;
      if (d < 0) begin
         flag(isodt_pkg::ERR_SYNTAX);
         return 1'b0;
      end
      v = prs.accum * 10 + d;
      if (v < lo || v > hi) begin
         flag(code);
         return 1'b0;
      end
      prs.accum = 14'(v);
      return 1'b1;
   endfunction

   function automatic void scan_char(logic [7:0] c);
      int d;
      d = (c >= "0" && c <= "9") ? int'(c - "0") : -1;
      case (prs.phase)
         isodt_pkg::PH_D0, isodt_pkg::PH_MO0, isodt_pkg::PH_DA0: begin
            if (d < 0) date_broken();
            else begin
               prs.accum = 14'(d);
               prs.phase = isodt_pkg::phase_type'(prs.phase << 1);
            end
         end
         isodt_pkg::PH_D1: begin
            if (d < 0) date_broken();
            else begin
               prs.accum    = 14'(prs.accum * 10 + d);
               prs.lead_bad = (prs.accum >= 24);
               prs.phase    = isodt_pkg::PH_SEL;
            end
         end
         isodt_pkg::PH_SEL: begin
            if (d >= 0) begin
               prs.accum = 14'(prs.accum * 10 + d);
               prs.phase = isodt_pkg::PH_Y3;
            end else if (prs.lead_bad) begin
               flag(isodt_pkg::ERR_HOUR);
            end else if (c == ":") begin
               prs.hour  = 5'(prs.accum);
               prs.phase = isodt_pkg::PH_MI0;
            end else begin
               flag(isodt_pkg::ERR_SYNTAX);
            end
         end
         isodt_pkg::PH_Y3: begin
            if (d < 0) date_broken();
            else begin
               prs.accum = 14'(prs.accum * 10 + d);
               prs.year  = prs.accum;
               prs.phase = isodt_pkg::PH_DASH1;
            end
         end
         isodt_pkg::PH_DASH1, isodt_pkg::PH_DASH2: begin
            if (c == "-") prs.phase = isodt_pkg::phase_type'(prs.phase << 1);
            else date_broken();
         end
         isodt_pkg::PH_MO1: begin
            if (d < 0) date_broken();
            else if (pair_ok(d, 1, 12, isodt_pkg::ERR_MONTH)) begin
               prs.month = 4'(prs.accum);
               prs.phase = isodt_pkg::PH_DASH2;
            end
         end
         isodt_pkg::PH_DA1: begin
            if (d < 0) date_broken();
            else if (pair_ok(d, 1, 31, isodt_pkg::ERR_DAY)) begin
               prs.day   = 5'(prs.accum);
               prs.phase = isodt_pkg::PH_AFTER_DATE;
            end
         end
         isodt_pkg::PH_AFTER_DATE: begin
            if (c == "T") prs.phase = isodt_pkg::PH_H0;
            else zone_open(c);
         end
         isodt_pkg::PH_H0, isodt_pkg::PH_MI0, isodt_pkg::PH_S0, isodt_pkg::PH_ZH0,
         isodt_pkg::PH_ZM0: begin
            if (d < 0) flag(isodt_pkg::ERR_SYNTAX);
            else begin
               prs.accum = 14'(d);
               prs.phase = isodt_pkg::phase_type'(prs.phase << 1);
            end
         end
         isodt_pkg::PH_H1: begin
            if (pair_ok(d, 0, 23, isodt_pkg::ERR_HOUR)) begin
               prs.hour  = 5'(prs.accum);
               prs.phase = isodt_pkg::PH_COL1;
            end
         end
         isodt_pkg::PH_MI1: begin
            if (pair_ok(d, 0, 59, isodt_pkg::ERR_MINUTE)) begin
               prs.minute = 6'(prs.accum);
               prs.phase  = isodt_pkg::PH_COL2;
            end
         end
         isodt_pkg::PH_S1: begin
            if (pair_ok(d, 0, 59, isodt_pkg::ERR_SECOND)) begin
               prs.second = 6'(prs.accum);
               prs.phase  = isodt_pkg::PH_AFTER_TIME;
            end
         end
         isodt_pkg::PH_COL1, isodt_pkg::PH_COL2, isodt_pkg::PH_ZCOL: begin
            if (c == ":") prs.phase = isodt_pkg::phase_type'(prs.phase << 1);
            else flag(isodt_pkg::ERR_SYNTAX);
         end
         isodt_pkg::PH_AFTER_TIME: zone_open(c);
         isodt_pkg::PH_ZH1: begin
            if (pair_ok(d, 0, 99, isodt_pkg::ERR_SYNTAX)) begin
               prs.zone_hours = 7'(prs.accum);
               prs.phase      = isodt_pkg::PH_ZCOL;
            end
         end
         isodt_pkg::PH_ZM1: begin
            if (d < 0) flag(isodt_pkg::ERR_SYNTAX);
            else begin
               prs.zone_offset = 13'(prs.zone_hours * 60 + prs.accum * 10 + d);
               prs.zone_kind   = prs.zone_neg ? isodt_pkg::ZONE_MINUS : isodt_pkg::ZONE_PLUS;
               prs.phase       = isodt_pkg::PH_END;
            end
         end
         default: flag(isodt_pkg::ERR_SYNTAX);
      endcase
   endfunction

   function automatic void take_char(logic [7:0] c, logic last);
      isodt_pkg::result_type r;
      if (prs.phase != isodt_pkg::PH_ERR) scan_char(c);
      if (!last) return;
      if (prs.error == isodt_pkg::ERR_NONE &&
          !(prs.phase inside {isodt_pkg::PH_AFTER_DATE, isodt_pkg::PH_AFTER_TIME,
                              isodt_pkg::PH_END})) begin
         // one-hot: every date phase sits below PH_AFTER_DATE
         if (prs.phase < isodt_pkg::PH_AFTER_DATE) date_broken();
         else flag(isodt_pkg::ERR_SYNTAX);
      end
      r = '0;
      r.error_code = prs.error;
      if (prs.error == isodt_pkg::ERR_NONE) begin
         r.year            = prs.year;
         r.month           = prs.month;
         r.day             = prs.day;
         r.hour            = prs.hour;
         r.minute          = prs.minute;
         r.second          = prs.second;
         r.zone_kind       = prs.zone_kind;
         r.zone_offset_min = prs.zone_offset;
      end
      parsed_q.push_back(r);
      prs = isodt_pkg::ST_RESET;
   endfunction

   // ---------------- stimulus ----------------

   task automatic queue_bytes(input char_list_type chars);
      for (int i = 0; i < chars.size(); i++)
         char_q.push_back('{chars[i], (i == chars.size() - 1)});
   endtask

   task automatic queue_text(input string s);
      char_list_type chars;
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      queue_bytes(chars);
   endtask

   // mostly in range, now and then anything two digits can hold
   function automatic int pick_field(int lo, int hi);
      if ($urandom_range(99) < 8) return $urandom_range(99);
      return $urandom_range(hi, lo);
   endfunction

   task automatic queue_random_string();
      string         s;
      int            form;
      int            n;
      char_list_type chars;
      form = $urandom_range(99);
      if (form >= 90) begin
         repeat ($urandom_range(20, 1)) chars.push_back(8'($urandom_range(255)));
      end else begin
         case ($urandom_range(2))
            0: s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", $urandom_range(9999),
                             pick_field(1, 12), pick_field(1, 31), pick_field(0, 23),
                             pick_field(0, 59), pick_field(0, 59));
            1: s = $sformatf("%04d-%02d-%02d", $urandom_range(9999), pick_field(1, 12),
                             pick_field(1, 31));
            default: s = $sformatf("%02d:%02d:%02d", pick_field(0, 23), pick_field(0, 59),
                                   pick_field(0, 59));
         endcase
         case ($urandom_range(3))
            1: s = {s, "Z"};
            2: s = {s, $sformatf("+%02d:%02d", $urandom_range(99), $urandom_range(99))};
            3: s = {s, $sformatf("-%02d:%02d", $urandom_range(99), $urandom_range(99))};
            default: ;
         endcase
         for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
         if (form >= 60) begin
            case ($urandom_range(2))
               0: begin
                  n = $urandom_range(chars.size() - 1, 1);
                  while (chars.size() > n) void'(chars.pop_back());
               end
               1: chars[$urandom_range(chars.size() - 1)] = 8'($urandom_range(255));
               default: repeat ($urandom_range(3, 1)) chars.push_back(8'($urandom_range(255)));
            endcase
         end
      end
      queue_bytes(chars);
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct);
      int target;
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      target = char_q.size() + 100;
      while (char_q.size() < target) queue_random_string();
      while (char_q.size() != 0 || parsed_q.size() != 0 || req_tvalid) @(posedge clock);
   endtask

   initial begin
      char_list_type odd;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_text("2024-02-29T23:59:59Z");
      queue_text("0000-01-01T00:00:00+00:00");
      queue_text("9999-12-31T23:59:59-99:99");
      queue_text("2024-06-15");
      queue_text("1987-11-05-04:30");
      queue_text("12:34:56");
      queue_text("00:00:00Z");
      queue_text("23:59:59+14:00");
      queue_text("2024-13-01");
      queue_text("2024-00-10");
      queue_text("2024-01-32");
      queue_text("2024-01-00");
      queue_text("2024-01-01T24:00:00");
      queue_text("2024-01-01T12:60:00");
      queue_text("2024-01-01T12:00:60Z");
      queue_text("24:00:00");
      queue_text("12:60:00");
      queue_text("23");
      queue_text("30");
      queue_text("7");
      queue_text("2024/01/01");
      queue_text("3024x");
      queue_text("2999-1");
      queue_text("12:34:56Zx");
      queue_text("12:34:56+05");
      queue_text("2024-13-32T99");
      odd.push_back(8'h00);
      odd.push_back(8'h80);
      odd.push_back(8'hFF);
      queue_bytes(odd);
      run_phase(0, 0);
      run_phase(74, 0);
      run_phase(0, 74);
      run_phase(20, 20);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("iso8601_datetime_parser regression: pass");
      end else begin
         $display("iso8601_datetime_parser regression: fail");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("iso8601_datetime_parser regression: fail");
      $finish;
   end

   // ---------------- driver ----------------

   always @(posedge clock) begin : req_driver
      logic show;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         show = req_tvalid;
         if (req_tvalid && req_tready) begin
            take_char(char_q[0].ch, char_q[0].last);
            void'(char_q.pop_front());
            show = 1'b0;
         end
         if (!show && char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) show = 1'b1;
         if (show) begin
            req_tdata <= char_q[0].ch;
            req_tlast <= char_q[0].last;
         end
         req_tvalid <= show;
      end
   end

   // ---------------- monitor ----------------

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch on result %0d: %s got %0d expected %0d",
                  results_seen, what, got, want);
   endtask

   always @(posedge clock) begin : rsp_monitor
      isodt_pkg::result_type got;
      isodt_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[isodt_pkg::RESULT_BITS-1:0];
         if (parsed_q.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = parsed_q.pop_front();
            if (got.error_code !== want.error_code)
               report_mismatch("error_code", got.error_code, want.error_code);
            if (got.year !== want.year) report_mismatch("year", got.year, want.year);
            if (got.month !== want.month) report_mismatch("month", got.month, want.month);
            if (got.day !== want.day) report_mismatch("day", got.day, want.day);
            if (got.hour !== want.hour) report_mismatch("hour", got.hour, want.hour);
            if (got.minute !== want.minute)
               report_mismatch("minute", got.minute, want.minute);
            if (got.second !== want.second)
               report_mismatch("second", got.second, want.second);
            if (got.zone_kind !== want.zone_kind)
               report_mismatch("zone_kind", got.zone_kind, want.zone_kind);
            if (got.zone_offset_min !== want.zone_offset_min)
               report_mismatch("zone_offset_min", got.zone_offset_min, want.zone_offset_min);
            if (rsp_tdata[isodt_pkg::RSP_BYTES*8-1:isodt_pkg::RESULT_BITS] !== '0)
               report_mismatch("zero fill",
                               rsp_tdata[isodt_pkg::RSP_BYTES*8-1:isodt_pkg::RESULT_BITS], 0);
         end
         results_seen++;
      end
      if (!reset) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

endmodule

### sim.f
design/isodt_pkg.sv
design/isodt_step.sv
design/iso8601_datetime_parser.sv
tb/sv/iso8601_datetime_parser_tb.sv
